// ===== hw/rtl/prjc_pkg.sv =====
package prjc_pkg;

  localparam int DEF_TABLE_DEPTH = 16;

  // field widths
  localparam int ROWIDX_W = 4;
  localparam int EDGE_W   = 13;
  localparam int SLOPE_W  = 17;
  localparam int PT_W     = 24;
  localparam int ETA_W    = 14;
  localparam int AREA_W   = 14;
  localparam int RHO_W    = 18;
  localparam int MU_W     = 12;
  localparam int NPV_W    = 8;
  localparam int EIU_W    = 5;
  localparam int CPT_W    = 25;
  localparam int SF_W     = 16;
  localparam int ST_W     = 2;

  // one table row: edge, vertex-count term, pileup term
  localparam int ROW_W = EDGE_W + 2 * SLOPE_W;

  // second operand of the shared multiplier
  localparam int MUL_B_W = 19;

  // quotient bits of the ratio divider; the top bit flags saturation
  localparam int SF_QBITS = 16;

  localparam int CPT_MAX = (1 << (CPT_W - 1)) - 1;
  localparam int CPT_MIN = -(1 << (CPT_W - 1));
  localparam int SF_MAX  = (1 << (SF_W - 1)) - 1;
  localparam int SF_MIN  = -(1 << (SF_W - 1));

  localparam logic [EIU_W-1:0] EIU_RESET = 5'd12;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CAL  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [ST_W-1:0] ST_PT_ZERO = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_INIT,
    S_BIN,
    S_ACCN,
    S_ACCM,
    S_FIN_N,
    S_FIN_M,
    S_FIN_A,
    S_ROUND,
    S_DIVGO,
    S_DIV,
    S_OUT
  } seq_state_t;

endpackage

// ===== hw/rtl/prjc_ram.sv =====
module prjc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/prjc_mul.sv =====
module prjc_mul #(
  parameter int A_W = 36,
  parameter int B_W = prjc_pkg::MUL_B_W
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   p
);

  // register the product before anyone adds it
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/prjc_div.sv =====
module prjc_div #(
  parameter int DW = 52
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 num,
  input  logic [DW-1:0]                 den,
  output logic [prjc_pkg::SF_QBITS-1:0] quo,
  output prjc_pkg::div_stat_t           stat
);

  import prjc_pkg::*;

  localparam int CW = $clog2(SF_QBITS);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(SF_QBITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= den << (SF_QBITS - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[SF_QBITS-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/pileup_residual_jet_correction.sv =====
// Pileup residual jet correction. A load transaction (func 0) writes one table row: an abs-eta
// bin edge and the vertex-count and pileup terms; a row_index at or above TABLE_DEPTH is
// dropped. A calibrate transaction (func 1) subtracts area times rho from the raw pt, walks
// the first edges_in_use edges to find the bin holding |eta|, integrates both piecewise-linear
// terms up to that point, subtracts npv_term*(npv-1) + mu_term*mu when a bin holds |eta|, and
// returns the rounded, saturated corrected pt, its Q2.14 ratio to the raw pt, and a status
// (ok, eta outside the table, raw pt zero). One registered multiplier does every product
// under a small sequencer, each visited bin passing through S_BIN, S_ACCN and S_ACCM, and a
// 16-step restoring divider forms the ratio. The walk covers at most edges_in_use edges,
// capped at TABLE_DEPTH; it stops early when |eta| falls in an early bin, and the divider is
// skipped when pt is zero. in_stall is high from acceptance until the result is in the
// output register. A finished result waits there, so the next transaction can be accepted
// while it is still stalled. Table rows read before they are loaded return undefined values.
// edges_in_use is written through the cfg channel, which is always ready; write it only while
// no transaction is in flight.
module pileup_residual_jet_correction #(
  parameter int TABLE_DEPTH = prjc_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic        [prjc_pkg::ROWIDX_W-1:0] row_index,
  input  logic        [prjc_pkg::EDGE_W-1:0]   edge_value,
  input  logic signed [prjc_pkg::SLOPE_W-1:0]  npv_slope,
  input  logic signed [prjc_pkg::SLOPE_W-1:0]  mu_slope,
  input  logic        [prjc_pkg::PT_W-1:0]     jet_pt,
  input  logic signed [prjc_pkg::ETA_W-1:0]    jet_eta,
  input  logic        [prjc_pkg::AREA_W-1:0]   catchment_area,
  input  logic        [prjc_pkg::RHO_W-1:0]    energy_density,
  input  logic        [prjc_pkg::MU_W-1:0]     pileup_mu,
  input  logic        [prjc_pkg::NPV_W-1:0]    vertex_count,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [prjc_pkg::CPT_W-1:0]    corrected_pt,
  output logic signed [prjc_pkg::SF_W-1:0]     scale_factor,
  output logic        [prjc_pkg::ST_W-1:0]     status,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [prjc_pkg::EIU_W-1:0]    cfg_data
);

  import prjc_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  // running offsets in units of 2^-20 MeV, with room for every bin
  localparam int OFS_W  = SLOPE_W + ETA_W + AW + 1;
  localparam int PROD_W = OFS_W + MUL_B_W;
  // running corrected pt in units of 2^-24 MeV
  localparam int TOT_W  = (OFS_W + 16 > 52) ? OFS_W + 16 : 52;
  localparam int SH_W   = TOT_W - 24;

  seq_state_t state;
  seq_state_t state_next;

  logic [EIU_W-1:0] edges_in_use;

  logic accept;
  logic load_we;

  // held jet fields
  logic [PT_W-1:0]   pt_r;
  logic [ETA_W-1:0]  aeta_r;
  logic [AREA_W-1:0] area_r;
  logic [RHO_W-1:0]  rho_r;
  logic [MU_W-1:0]   mu_r;
  logic [NPV_W-1:0]  npv_r;
  logic [CNT_W-1:0]  n_lim;

  // bin walk
  logic [CNT_W-1:0]          idx;
  logic [CNT_W:0]            idx_inc;
  logic                      last_bin;
  logic [EDGE_W-1:0]         prev_edge;
  logic signed [ETA_W:0]     delta_r;
  logic signed [ETA_W:0]     delta_c;
  logic signed [SLOPE_W-1:0] tm_r;
  logic                      found;
  logic                      hit;
  logic signed [OFS_W-1:0]   off_n;
  logic signed [OFS_W-1:0]   off_m;

  // totals and rounding
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] pt_term;
  logic signed [TOT_W-1:0] rnd;
  logic signed [SH_W-1:0]  sh;
  logic signed [CPT_W-1:0] cpt_c;
  logic signed [CPT_W-1:0] cpt_r;
  logic [TOT_W-1:0]        mag_r;
  logic                    neg_r;
  logic                    pt_zero;

  logic [ETA_W-1:0]     eta_abs;
  logic signed [NPV_W:0] npv_m1;

  // table memory
  logic [AW-1:0]             rd_addr;
  logic [ROW_W-1:0]          rd_row;
  logic [EDGE_W-1:0]         rd_edge;
  logic signed [SLOPE_W-1:0] rd_npv;
  logic signed [SLOPE_W-1:0] rd_mu;

  // shared multiplier
  logic signed [OFS_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // divider
  logic                div_start;
  logic [TOT_W-1:0]    div_num;
  logic [TOT_W-1:0]    div_den;
  logic [SF_QBITS-1:0] quo;
  div_stat_t           div_stat;

  logic                   out_free;
  logic signed [SF_W-1:0] sf_c;
  logic [ST_W-1:0]        status_c;

  assign accept  = in_valid && !in_stall;
  assign load_we = accept && (func == FUNC_LOAD) && (int'(row_index) < TABLE_DEPTH);

  assign eta_abs = jet_eta[ETA_W-1] ? ETA_W'(-jet_eta) : ETA_W'(jet_eta);
  assign npv_m1  = $signed({1'b0, npv_r}) - $signed((NPV_W + 1)'(1));

  assign rd_edge = rd_row[ROW_W-1 -: EDGE_W];
  assign rd_npv  = $signed(rd_row[2*SLOPE_W-1 -: SLOPE_W]);
  assign rd_mu   = $signed(rd_row[SLOPE_W-1:0]);

  // bin i runs from the previous edge up to, not including, the edge just read
  assign hit     = (aeta_r >= {1'b0, prev_edge}) && (aeta_r < {1'b0, rd_edge});
  assign delta_c = $signed({1'b0, hit ? aeta_r : {1'b0, rd_edge}}) - $signed({2'b00, prev_edge});

  assign idx_inc  = {1'b0, idx} + (CNT_W + 1)'(1);
  assign last_bin = idx_inc >= {1'b0, n_lim};

  assign pt_zero = pt_r == '0;
  assign pt_term = $signed(TOT_W'(pt_r) << 24);

  // round to nearest, ties upward, then saturate to the output range
  assign rnd = total + $signed(TOT_W'(1) << 23);
  assign sh  = $signed(rnd[TOT_W-1:24]);

  always_comb begin
    if (sh > SH_W'(CPT_MAX)) begin
      cpt_c = CPT_W'(CPT_MAX);
    end else if (sh < SH_W'(CPT_MIN)) begin
      cpt_c = CPT_W'(CPT_MIN);
    end else begin
      cpt_c = CPT_W'(sh);
    end
  end

  // |total| + d/2 over d = pt*1024 gives the ratio rounded half away from zero
  assign div_num = mag_r + (TOT_W'(pt_r) << 9);
  assign div_den = TOT_W'(pt_r) << 10;

  always_comb begin
    if (pt_zero) begin
      sf_c = '0;
    end else if (quo[SF_QBITS-1]) begin
      sf_c = neg_r ? SF_W'(SF_MIN) : SF_W'(SF_MAX);
    end else if (neg_r) begin
      sf_c = -$signed({1'b0, quo[SF_QBITS-2:0]});
    end else begin
      sf_c = $signed({1'b0, quo[SF_QBITS-2:0]});
    end
  end

  always_comb begin
    if (pt_zero) begin
      status_c = ST_PT_ZERO;
    end else if (found) begin
      status_c = ST_OK;
    end else begin
      status_c = ST_OUTSIDE;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edges_in_use <= EIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      edges_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, input stall, table read address, multiplier operands, divider start
  always_comb begin
    state_next = state;
    in_stall   = state != S_IDLE;
    rd_addr    = '0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (func == FUNC_CAL)) begin
          state_next = S_AREA;
        end
      end
      S_AREA: begin
        // area*rho now, row 0 arrives next cycle
        mul_a      = $signed(OFS_W'(area_r));
        mul_b      = $signed(MUL_B_W'(rho_r));
        state_next = S_INIT;
      end
      S_INIT: begin
        if (n_lim < CNT_W'(2)) begin
          state_next = S_ROUND;
        end else begin
          rd_addr    = AW'(1);
          state_next = S_BIN;
        end
      end
      S_BIN: begin
        mul_a      = OFS_W'(rd_npv);
        mul_b      = MUL_B_W'(delta_c);
        state_next = S_ACCN;
      end
      S_ACCN: begin
        mul_a      = OFS_W'(tm_r);
        mul_b      = MUL_B_W'(delta_r);
        state_next = S_ACCM;
      end
      S_ACCM: begin
        if (found) begin
          state_next = S_FIN_N;
        end else if (last_bin) begin
          state_next = S_ROUND;
        end else begin
          rd_addr    = idx_inc[AW-1:0];
          state_next = S_BIN;
        end
      end
      S_FIN_N: begin
        mul_a      = off_n;
        mul_b      = MUL_B_W'(npv_m1);
        state_next = S_FIN_M;
      end
      S_FIN_M: begin
        mul_a      = off_m;
        mul_b      = $signed(MUL_B_W'(mu_r));
        state_next = S_FIN_A;
      end
      S_FIN_A: begin
        state_next = S_ROUND;
      end
      S_ROUND: begin
        state_next = pt_zero ? S_OUT : S_DIVGO;
      end
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          pt_r   <= jet_pt;
          aeta_r <= eta_abs;
          area_r <= catchment_area;
          rho_r  <= energy_density;
          mu_r   <= pileup_mu;
          npv_r  <= vertex_count;
          n_lim  <= (int'(edges_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(edges_in_use);
        end
      end
      S_INIT: begin
        total     <= pt_term - (TOT_W'(prod) <<< 12);
        off_n     <= OFS_W'(rd_npv) <<< 10;
        off_m     <= OFS_W'(rd_mu) <<< 10;
        prev_edge <= rd_edge;
        idx       <= CNT_W'(1);
        found     <= 1'b0;
      end
      S_BIN: begin
        found     <= hit;
        delta_r   <= delta_c;
        tm_r      <= rd_mu;
        prev_edge <= rd_edge;
      end
      S_ACCN: begin
        off_n <= off_n + OFS_W'(prod);
      end
      S_ACCM: begin
        off_m <= off_m + OFS_W'(prod);
        if (!found && !last_bin) begin
          idx <= idx_inc[CNT_W-1:0];
        end
      end
      S_FIN_M: begin
        total <= total - (TOT_W'(prod) <<< 4);
      end
      S_FIN_A: begin
        total <= total - TOT_W'(prod);
      end
      S_ROUND: begin
        cpt_r <= cpt_c;
        neg_r <= total[TOT_W-1];
        mag_r <= total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
      end
      default: begin
      end
    endcase
  end

  // output register: parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      corrected_pt <= cpt_r;
      scale_factor <= sf_c;
      status       <= status_c;
    end
  end

  prjc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(row_index)),
    .wdata ({edge_value, npv_slope, mu_slope}),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  prjc_mul #(
    .A_W (OFS_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  prjc_div #(
    .DW (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  a_cal_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_CAL) |=> state == S_AREA)
    else $error("calibrate transaction did not start the sequencer");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BIN |-> (idx != '0) && (idx < n_lim))
    else $error("bin walk left the edge range");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_zero_pt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PT_ZERO) |-> scale_factor == '0)
    else $error("zero pt result carries a nonzero ratio");

endmodule

// ===== tb/jet_calib_checker.sv =====
`timescale 1ns / 1ps

module jet_calib_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 func,
  input  logic        [prjc_pkg::ROWIDX_W-1:0] row_index,
  input  logic        [prjc_pkg::EDGE_W-1:0]   edge_value,
  input  logic signed [prjc_pkg::SLOPE_W-1:0]  npv_slope,
  input  logic signed [prjc_pkg::SLOPE_W-1:0]  mu_slope,
  input  logic        [prjc_pkg::PT_W-1:0]     jet_pt,
  input  logic signed [prjc_pkg::ETA_W-1:0]    jet_eta,
  input  logic        [prjc_pkg::AREA_W-1:0]   catchment_area,
  input  logic        [prjc_pkg::RHO_W-1:0]    energy_density,
  input  logic        [prjc_pkg::MU_W-1:0]     pileup_mu,
  input  logic        [prjc_pkg::NPV_W-1:0]    vertex_count,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [prjc_pkg::CPT_W-1:0]    corrected_pt,
  input  logic signed [prjc_pkg::SF_W-1:0]     scale_factor,
  input  logic        [prjc_pkg::ST_W-1:0]     status,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [prjc_pkg::EIU_W-1:0]    cfg_data,
  output int                                   mismatches,
  output int                                   outstanding
);

  import prjc_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [CPT_W-1:0] cpt;
    logic signed [SF_W-1:0]  sf;
    logic        [ST_W-1:0]  st;
  } jet_result_t;

  logic        [EDGE_W-1:0]  edge_row [DEF_TABLE_DEPTH];
  logic signed [SLOPE_W-1:0] npv_row  [DEF_TABLE_DEPTH];
  logic signed [SLOPE_W-1:0] mu_row   [DEF_TABLE_DEPTH];
  logic        [EIU_W-1:0]   edges_used;
  jet_result_t               expected_jets [$];
  jet_result_t               oldest_jet;

  // Area subtraction, then the piecewise-linear residual at |eta|; exact 64-bit math.
  function automatic jet_result_t calibrate_jet(
    input logic        [PT_W-1:0]   pt_raw,
    input logic signed [ETA_W-1:0]  eta,
    input logic        [AREA_W-1:0] area,
    input logic        [RHO_W-1:0]  rho,
    input logic        [MU_W-1:0]   mu,
    input logic        [NPV_W-1:0]  npv
  );
    longint          abs_eta, n_edges, off_n, off_m, lo, hi, slope_n, slope_m;
    longint          at_n, at_m, total, cpt, sf;
    longint unsigned mag, den, quo;
    bit              hit;
    int              i;
    jet_result_t     r;
    abs_eta = (eta < 0) ? -longint'(eta) : longint'(eta);
    n_edges = (edges_used > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : longint'(edges_used);
    hit  = 1'b0;
    at_n = 0;
    at_m = 0;
    if (n_edges >= 2) begin
      // offsets at the lower edge of the current bin, units of 2^-20 MeV
      off_n = longint'(npv_row[0]) * 1024;
      off_m = longint'(mu_row[0]) * 1024;
      for (i = 0; i + 1 < n_edges && !hit; i++) begin
        lo      = longint'(edge_row[i]);
        hi      = longint'(edge_row[i + 1]);
        slope_n = longint'(npv_row[i + 1]);
        slope_m = longint'(mu_row[i + 1]);
        if (abs_eta >= lo && abs_eta < hi) begin
          at_n = off_n + (abs_eta - lo) * slope_n;
          at_m = off_m + (abs_eta - lo) * slope_m;
          hit  = 1'b1;
        end else begin
          off_n += slope_n * (hi - lo);
          off_m += slope_m * (hi - lo);
        end
      end
    end
    // total in units of 2^-24 MeV
    total = longint'(pt_raw) * (longint'(1) << 24)
            - longint'(area) * longint'(rho) * 4096;
    if (hit)
      total -= at_n * (longint'(npv) - 1) * 16 + at_m * longint'(mu);
    cpt = (total + (longint'(1) << 23)) >>> 24;
    if (cpt > CPT_MAX) cpt = CPT_MAX;
    if (cpt < CPT_MIN) cpt = CPT_MIN;
    if (pt_raw != 0) begin
      den = longint'(pt_raw) * 1024;
      mag = (total < 0) ? -total : total;
      quo = (mag + den / 2) / den;
      if (quo > 65536) quo = 65536;
      sf = (total < 0) ? -longint'(quo) : longint'(quo);
      if (sf > SF_MAX) sf = SF_MAX;
      if (sf < SF_MIN) sf = SF_MIN;
      r.st = hit ? ST_OK : ST_OUTSIDE;
    end else begin
      sf   = 0;
      r.st = ST_PT_ZERO;
    end
    r.cpt = cpt[CPT_W-1:0];
    r.sf  = sf[SF_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      edges_used = EIU_RESET;
      expected_jets.delete();
      outstanding <= 0;
    end else begin
      // retire before queueing, so a result never meets its own prediction
      if (out_valid && !out_stall) begin
        if (expected_jets.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result: corrected_pt %0d scale_factor %0d status %0d",
                     $realtime, corrected_pt, scale_factor, status);
        end else begin
          oldest_jet = expected_jets.pop_front();
          if (corrected_pt !== oldest_jet.cpt || scale_factor !== oldest_jet.sf ||
              status !== oldest_jet.st) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: mismatch: corrected_pt exp %0d got %0d, ",
                        "scale_factor exp %0d got %0d, status exp %0d got %0d"},
                       $realtime, oldest_jet.cpt, corrected_pt, oldest_jet.sf, scale_factor,
                       oldest_jet.st, status);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        edges_used = cfg_data;
      if (in_valid && !in_stall) begin
        if (func == FUNC_LOAD) begin
          edge_row[row_index] = edge_value;
          npv_row[row_index]  = npv_slope;
          mu_row[row_index]   = mu_slope;
        end else begin
          expected_jets.insert(expected_jets.size(),
                               calibrate_jet(jet_pt, jet_eta, catchment_area, energy_density,
                                             pileup_mu, vertex_count));
        end
      end
      outstanding <= expected_jets.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import prjc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 10;
  // drain well past the longest calibrate transaction, a walk over every table edge
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASES       = 8;
  localparam int JETS_PER_PHASE = 110;

  typedef struct packed {
    logic                      func;
    logic        [ROWIDX_W-1:0] row;
    logic        [EDGE_W-1:0]   edge_v;
    logic signed [SLOPE_W-1:0]  ns;
    logic signed [SLOPE_W-1:0]  ms;
    logic        [PT_W-1:0]     pt;
    logic signed [ETA_W-1:0]    eta;
    logic        [AREA_W-1:0]   area;
    logic        [RHO_W-1:0]    rho;
    logic        [MU_W-1:0]     mu;
    logic        [NPV_W-1:0]    npv;
  } jet_item_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      func = FUNC_LOAD;
  logic        [ROWIDX_W-1:0] row_index = '0;
  logic        [EDGE_W-1:0]   edge_value = '0;
  logic signed [SLOPE_W-1:0]  npv_slope = '0;
  logic signed [SLOPE_W-1:0]  mu_slope = '0;
  logic        [PT_W-1:0]     jet_pt = '0;
  logic signed [ETA_W-1:0]    jet_eta = '0;
  logic        [AREA_W-1:0]   catchment_area = '0;
  logic        [RHO_W-1:0]    energy_density = '0;
  logic        [MU_W-1:0]     pileup_mu = '0;
  logic        [NPV_W-1:0]    vertex_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [CPT_W-1:0]    corrected_pt;
  logic signed [SF_W-1:0]     scale_factor;
  logic        [ST_W-1:0]     status;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic        [EIU_W-1:0]    cfg_data = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // bump hold_req to ask the receiver for one long hold-off
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  // highest edge of the loaded table; aim most jets below it
  int table_top = 8191;

  always #(CLK_PERIOD / 2) clk = ~clk;

  pileup_residual_jet_correction i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .row_index      (row_index),
    .edge_value     (edge_value),
    .npv_slope      (npv_slope),
    .mu_slope       (mu_slope),
    .jet_pt         (jet_pt),
    .jet_eta        (jet_eta),
    .catchment_area (catchment_area),
    .energy_density (energy_density),
    .pileup_mu      (pileup_mu),
    .vertex_count   (vertex_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .corrected_pt   (corrected_pt),
    .scale_factor   (scale_factor),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  jet_calib_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .row_index      (row_index),
    .edge_value     (edge_value),
    .npv_slope      (npv_slope),
    .mu_slope       (mu_slope),
    .jet_pt         (jet_pt),
    .jet_eta        (jet_eta),
    .catchment_area (catchment_area),
    .energy_density (energy_density),
    .pileup_mu      (pileup_mu),
    .vertex_count   (vertex_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .corrected_pt   (corrected_pt),
    .scale_factor   (scale_factor),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Receiver: random stall at the phase's rate; on request, hold off for a long
  // stretch so the result register stays full and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Fill every field but func at random; the unused half of a transaction still toggles.
  function automatic jet_item_t scatter_fields();
    jet_item_t it;
    it.func   = FUNC_CAL;
    it.row    = ROWIDX_W'($urandom());
    it.edge_v = EDGE_W'($urandom());
    it.ns     = SLOPE_W'($urandom());
    it.ms     = SLOPE_W'($urandom());
    it.pt     = PT_W'($urandom());
    it.eta    = ETA_W'($urandom());
    it.area   = AREA_W'($urandom());
    it.rho    = RHO_W'($urandom());
    it.mu     = MU_W'($urandom());
    it.npv    = NPV_W'($urandom());
    return it;
  endfunction

  function automatic jet_item_t row_item(int row, int edge_v, int ns, int ms);
    jet_item_t it;
    it        = scatter_fields();
    it.func   = FUNC_LOAD;
    it.row    = ROWIDX_W'(row);
    it.edge_v = EDGE_W'(edge_v);
    it.ns     = SLOPE_W'(ns);
    it.ms     = SLOPE_W'(ms);
    return it;
  endfunction

  function automatic jet_item_t jet_item(int pt, int eta, int area, int rho, int mu, int npv);
    jet_item_t it;
    it      = scatter_fields();
    it.func = FUNC_CAL;
    it.pt   = PT_W'(pt);
    it.eta  = ETA_W'(eta);
    it.area = AREA_W'(area);
    it.rho  = RHO_W'(rho);
    it.mu   = MU_W'(mu);
    it.npv  = NPV_W'(npv);
    return it;
  endfunction

  // Random jet: mostly inside the loaded edges, some anywhere in the eta range.
  function automatic jet_item_t random_jet();
    jet_item_t it;
    int        sel, mag;
    it  = scatter_fields();
    sel = $urandom_range(9);
    if (sel == 0)
      it.pt = '0;
    else if (sel == 1)
      it.pt = PT_W'($urandom_range(1, 255));
    else if (sel == 2)
      it.pt = {PT_W{1'b1}};
    if ($urandom_range(99) < 85) begin
      mag    = $urandom_range(0, table_top);
      it.eta = ETA_W'($urandom_range(1) ? -mag : mag);
    end
    if ($urandom_range(3) == 0)
      it.rho = RHO_W'($urandom_range(0, 4095));
    return it;
  endfunction

  // Offer one transaction after a random gap; hold it until the block takes it.
  task automatic offer(input jet_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= it.func;
    row_index      <= it.row;
    edge_value     <= it.edge_v;
    npv_slope      <= it.ns;
    mu_slope       <= it.ms;
    jet_pt         <= it.pt;
    jet_eta        <= it.eta;
    catchment_area <= it.area;
    energy_density <= it.rho;
    pileup_mu      <= it.mu;
    vertex_count   <= it.npv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result is out, then let any
  // trailing work finish so a register write lands on an idle block.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_edges_in_use(input int count);
    cfg_valid <= 1'b1;
    cfg_data  <= EIU_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load all sixteen rows: sorted edges with random steps, sorted with many
  // empty bins, or fully unsorted.
  task automatic load_table(input int shape);
    int e, r, max_step;
    e        = $urandom_range(1) ? 0 : $urandom_range(0, 200);
    max_step = (shape == 2) ? 3 : 1100;
    table_top = 0;
    for (r = 0; r < DEF_TABLE_DEPTH; r++) begin
      if (shape == 1)
        e = $urandom_range(0, 8191);
      offer(row_item(r, e, $urandom(), $urandom()));
      if (e > table_top) table_top = e;
      if (shape != 1) begin
        e += $urandom_range(0, max_step);
        if (e > 8191) e = 8191;
      end
    end
  endtask

  initial begin
    int phase, k;
    int eiu_plan [PHASES];

    eiu_plan = '{2, 16, 31, 0, 7, 1, 16, 12};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a known table with extreme terms, edges_in_use at its reset value.
    for (k = 0; k < DEF_TABLE_DEPTH; k++) begin
      if (k % 4 == 3)
        offer(row_item(k, k * 546, $urandom(), $urandom()));
      else
        offer(row_item(k, (k == DEF_TABLE_DEPTH - 1) ? 8191 : k * 546,
                       (k % 2) ? -65536 : 65535, (k % 2) ? 65535 : -65536));
    end
    table_top = 8191;
    offer(jet_item(0, 100, 1000, 5000, 400, 30));                   // zero raw pt
    offer(jet_item(16777215, 0, 16383, 262143, 4095, 255));         // all maxima, first bin
    offer(jet_item(50000, -8192, 0, 0, 0, 1));                      // most negative eta
    offer(jet_item(50000, 8191, 100, 100, 100, 10));                // beyond every edge
    offer(jet_item(800000, 6006, 2000, 20000, 500, 20));            // top edge in use
    offer(jet_item(800000, -6005, 2000, 20000, 500, 20));           // last bin in use
    offer(jet_item(300000, 546, 1500, 15000, 640, 0));              // on an edge, no vertices
    offer(jet_item(1, -3000, 16383, 262143, 4095, 255));            // tiny pt, ratio saturates
    offer(jet_item(16777215, 2000, 0, 0, 4095, 255));               // pt may saturate high
    settle();

    // Random phases: new register value and table each time, cycling idle modes.
    for (phase = 0; phase < PHASES; phase++) begin
      write_edges_in_use(eiu_plan[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct = 9; recv_stall_pct <= 9; end
      endcase
      load_table((phase == 5) ? 1 : (phase == 4) ? 2 : 0);
      // back the block up once while the sender keeps offering
      if (phase == 0) hold_req <= hold_req + 1;
      for (k = 0; k < JETS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 6)
          offer(row_item($urandom(), $urandom(), $urandom(), $urandom()));
        else
          offer(random_jet());
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
